[hdl/i2c_master_bit_engine_unit_defines.svh]
// Assertion macros shared by the checker of the I2C master bit engine.
// No dependencies; taken in by `include where assertions are written.
`ifndef I2C_MASTER_BIT_ENGINE_UNIT_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define I2C_MEB_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication, disabled while reset is asserted
`define I2C_MEB_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

[hdl/i2c_meb_pkg.sv]
// Shared types and constants of the I2C master bit engine.
// No dependencies; used by front, queue, back and top level by scoped names.
package i2c_meb_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_BUS_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_US  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_LIMIT = 2'd2;

  localparam logic [8:0] BUS_SPEED_RST = 9'd0;
  localparam logic [7:0] TICKS_US_RST  = 8'd1;
  localparam logic [7:0] ACK_LIMIT_RST = 8'd250;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // wait counter: four delay units of up to 255 ticks
  localparam int unsigned WAIT_W = 11;

  // operation codes on the input channel
  localparam logic [2:0] OP_NONE      = 3'd0;
  localparam logic [2:0] OP_START     = 3'd1;
  localparam logic [2:0] OP_STOP      = 3'd2;
  localparam logic [2:0] OP_WRITE     = 3'd3;
  localparam logic [2:0] OP_READ_ACK  = 3'd4;
  localparam logic [2:0] OP_READ_NACK = 3'd5;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_READ_ACK,
    CMD_READ_NACK
  } cmd_kind_e;

  // one classified tick as it travels through the queue
  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] tx_byte;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic [8:0] bus_speed_khz;
    logic [7:0] ticks_per_us;
    logic [7:0] ack_poll_limit;
  } cfg_t;

endpackage

[hdl/i2c_meb_front.sv]
// Front end of the I2C master bit engine: input handshake and command decode.
// Depends on i2c_meb_pkg; feeds i2c_meb_queue.
module i2c_meb_front (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         operation_i,
  input  logic [7:0]         tx_byte_i,
  input  logic               sda_in_i,
  input  logic               q_full_i,
  output logic               push_o,
  output i2c_meb_pkg::item_t item_o
);

  // take a transaction whenever the queue has room
  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // classify the operation; unused codes behave as no command
  always_comb begin
    item_o.tx_byte = tx_byte_i;
    item_o.sda_in  = sda_in_i;
    case (operation_i)
      i2c_meb_pkg::OP_NONE:      item_o.kind = i2c_meb_pkg::CMD_NONE;
      i2c_meb_pkg::OP_START:     item_o.kind = i2c_meb_pkg::CMD_START;
      i2c_meb_pkg::OP_STOP:      item_o.kind = i2c_meb_pkg::CMD_STOP;
      i2c_meb_pkg::OP_WRITE:     item_o.kind = i2c_meb_pkg::CMD_WRITE;
      i2c_meb_pkg::OP_READ_ACK:  item_o.kind = i2c_meb_pkg::CMD_READ_ACK;
      i2c_meb_pkg::OP_READ_NACK: item_o.kind = i2c_meb_pkg::CMD_READ_NACK;
      default:                   item_o.kind = i2c_meb_pkg::CMD_NONE;
    endcase
  end

endmodule

[hdl/i2c_meb_queue.sv]
// Short FIFO of classified ticks between front and back of the bit engine.
// Depends on i2c_meb_pkg for the item type.
module i2c_meb_queue #(
  parameter int unsigned Depth = i2c_meb_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  i2c_meb_pkg::item_t item_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               valid_o,
  output i2c_meb_pkg::item_t item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  i2c_meb_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[hdl/i2c_meb_back.sv]
// Back end of the I2C master bit engine: line sequencer and result register.
// Depends on i2c_meb_pkg; drains i2c_meb_queue one tick per cycle unless stalled.
module i2c_meb_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  i2c_meb_pkg::cfg_t  cfg_i,
  input  logic               q_valid_i,
  input  i2c_meb_pkg::item_t q_item_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               scl_level_o,
  output logic               sda_level_o,
  output logic               busy_res_o,
  output logic               done_res_o,
  output logic [7:0]         rx_byte_o,
  output logic               ack_error_o,
  output logic               refused_o
);

  localparam int unsigned WaitW = i2c_meb_pkg::WAIT_W;

  // sequencer phases
  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_ST_A     = 4'd1;
  localparam logic [3:0] PH_ST_B     = 4'd2;
  localparam logic [3:0] PH_SP_A     = 4'd3;
  localparam logic [3:0] PH_SP_B     = 4'd4;
  localparam logic [3:0] PH_WR_SETUP = 4'd5;
  localparam logic [3:0] PH_WR_HIGH  = 4'd6;
  localparam logic [3:0] PH_WR_LOW   = 4'd7;
  localparam logic [3:0] PH_ACK_REL  = 4'd8;
  localparam logic [3:0] PH_ACK_HIGH = 4'd9;
  localparam logic [3:0] PH_ACK_POLL = 4'd10;
  localparam logic [3:0] PH_RD_LOW   = 4'd11;
  localparam logic [3:0] PH_RD_HIGH  = 4'd12;
  localparam logic [3:0] PH_AK_LOW   = 4'd13;
  localparam logic [3:0] PH_AK_HIGH  = 4'd14;

  logic [3:0]       ph_q, ph_d;
  logic [3:0]       bit_q, bit_d;
  logic [WaitW-1:0] wait_q, wait_d;
  logic [7:0]       poll_q, poll_d;
  logic [7:0]       shift_q, shift_d;
  logic             ack_rd_q, ack_rd_d;
  logic             scl_q, scl_d;
  logic             sda_q, sda_d;
  logic [7:0]       rx_q, rx_d;
  logic             aerr_q, aerr_d;

  logic             out_valid_q;
  logic             done_q, refused_q, busy_q;

  logic [7:0]       unit_ticks;
  logic [WaitW-1:0] long_wait, short_wait, wait_dec;
  logic [7:0]       poll_base;
  logic             is_cmd, is_read, done, refused;

  // one tick is consumed whenever the result register is free or draining
  assign q_pop_o = q_valid_i && (!out_valid_q || out_ready_i);

  // delay lengths: four and two units, a zero tick count counts as one
  assign unit_ticks = (cfg_i.ticks_per_us == 8'd0) ? 8'd1 : cfg_i.ticks_per_us;
  assign long_wait  = {1'b0, unit_ticks, 2'b00};
  assign short_wait = {2'b00, unit_ticks, 1'b0};
  assign wait_dec   = (wait_q != '0) ? wait_q - WaitW'(1) : '0;
  assign poll_base  = (ph_q == PH_ACK_HIGH) ? 8'd0 : poll_q;

  assign is_cmd  = (q_item_i.kind != i2c_meb_pkg::CMD_NONE);
  assign is_read = (q_item_i.kind == i2c_meb_pkg::CMD_READ_ACK) ||
                   (q_item_i.kind == i2c_meb_pkg::CMD_READ_NACK);

  // next state of the line sequencer for the tick at the queue head
  always_comb begin
    ph_d     = ph_q;
    bit_d    = bit_q;
    wait_d   = wait_q;
    poll_d   = poll_q;
    shift_d  = shift_q;
    ack_rd_d = ack_rd_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    rx_d     = rx_q;
    aerr_d   = aerr_q;
    done     = 1'b0;
    refused  = 1'b0;

    if (ph_q == PH_IDLE) begin
      // idle: launch a command unless the bus is not set up
      if (is_cmd) begin
        if (cfg_i.bus_speed_khz == '0) begin
          refused = 1'b1;
        end else begin
          case (q_item_i.kind)
            i2c_meb_pkg::CMD_START: begin
              sda_d  = 1'b1;
              scl_d  = 1'b1;
              ph_d   = PH_ST_A;
              wait_d = long_wait;
            end
            i2c_meb_pkg::CMD_STOP: begin
              scl_d  = 1'b0;
              sda_d  = 1'b0;
              ph_d   = PH_SP_A;
              wait_d = long_wait;
            end
            i2c_meb_pkg::CMD_WRITE: begin
              scl_d   = 1'b0;
              sda_d   = q_item_i.tx_byte[7];
              shift_d = {q_item_i.tx_byte[6:0], 1'b0};
              bit_d   = 4'd1;
              ph_d    = PH_WR_SETUP;
              wait_d  = short_wait;
            end
            default: begin
              scl_d    = 1'b0;
              sda_d    = 1'b1;
              shift_d  = 8'd0;
              bit_d    = 4'd0;
              ack_rd_d = (q_item_i.kind == i2c_meb_pkg::CMD_READ_ACK);
              ph_d     = PH_RD_LOW;
              wait_d   = short_wait;
            end
          endcase
        end
      end
    end else begin
      // busy: any command is refused, the running one advances
      refused = is_cmd;
      wait_d  = wait_dec;
      if (ph_q == PH_ACK_POLL || wait_dec == '0) begin
        case (ph_q)
          PH_ST_A: begin
            sda_d  = 1'b0;
            ph_d   = PH_ST_B;
            wait_d = long_wait;
          end
          PH_ST_B: begin
            scl_d = 1'b0;
            ph_d  = PH_IDLE;
            done  = 1'b1;
          end
          PH_SP_A: begin
            scl_d  = 1'b1;
            sda_d  = 1'b1;
            ph_d   = PH_SP_B;
            wait_d = long_wait;
          end
          PH_SP_B: begin
            ph_d = PH_IDLE;
            done = 1'b1;
          end
          PH_WR_SETUP: begin
            scl_d  = 1'b1;
            ph_d   = PH_WR_HIGH;
            wait_d = short_wait;
          end
          PH_WR_HIGH: begin
            scl_d  = 1'b0;
            ph_d   = PH_WR_LOW;
            wait_d = short_wait;
          end
          PH_WR_LOW: begin
            if (bit_q < 4'd8) begin
              sda_d   = shift_q[7];
              shift_d = {shift_q[6:0], 1'b0};
              bit_d   = bit_q + 4'd1;
              ph_d    = PH_WR_SETUP;
            end else begin
              sda_d = 1'b1;
              ph_d  = PH_ACK_REL;
            end
            wait_d = short_wait;
          end
          PH_ACK_REL: begin
            scl_d  = 1'b1;
            ph_d   = PH_ACK_HIGH;
            wait_d = short_wait;
          end
          PH_ACK_HIGH, PH_ACK_POLL: begin
            // acknowledge poll, one sample of SDA per tick
            if (!q_item_i.sda_in) begin
              scl_d  = 1'b0;
              aerr_d = 1'b0;
              ph_d   = PH_IDLE;
              done   = 1'b1;
            end else if (poll_base >= cfg_i.ack_poll_limit) begin
              scl_d  = 1'b0;
              aerr_d = 1'b1;
              ph_d   = PH_IDLE;
              done   = 1'b1;
            end else begin
              poll_d = poll_base + 8'd1;
              ph_d   = PH_ACK_POLL;
            end
          end
          PH_RD_LOW: begin
            scl_d   = 1'b1;
            shift_d = {shift_q[6:0], q_item_i.sda_in};
            bit_d   = bit_q + 4'd1;
            ph_d    = PH_RD_HIGH;
            wait_d  = short_wait;
          end
          PH_RD_HIGH: begin
            scl_d = 1'b0;
            if (bit_q < 4'd8) begin
              ph_d = PH_RD_LOW;
            end else begin
              sda_d = !ack_rd_q;
              ph_d  = PH_AK_LOW;
            end
            wait_d = short_wait;
          end
          PH_AK_LOW: begin
            scl_d  = 1'b1;
            ph_d   = PH_AK_HIGH;
            wait_d = short_wait;
          end
          PH_AK_HIGH: begin
            scl_d = 1'b0;
            rx_d  = shift_q;
            ph_d  = PH_IDLE;
            done  = 1'b1;
          end
          default: begin
            ph_d = PH_IDLE;
          end
        endcase
      end
    end

    // a refused read reports all ones
    if (refused && is_read) begin
      rx_d = 8'hFF;
    end
  end

  // sequencer state, advanced once per consumed tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q     <= PH_IDLE;
      bit_q    <= '0;
      wait_q   <= '0;
      poll_q   <= '0;
      shift_q  <= '0;
      ack_rd_q <= 1'b0;
      scl_q    <= 1'b1;
      sda_q    <= 1'b1;
      rx_q     <= '0;
      aerr_q   <= 1'b0;
    end else if (q_pop_o) begin
      ph_q     <= ph_d;
      bit_q    <= bit_d;
      wait_q   <= wait_d;
      poll_q   <= poll_d;
      shift_q  <= shift_d;
      ack_rd_q <= ack_rd_d;
      scl_q    <= scl_d;
      sda_q    <= sda_d;
      rx_q     <= rx_d;
      aerr_q   <= aerr_d;
    end
  end

  // result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // per-tick flags of the result register
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      done_q    <= done;
      refused_q <= refused;
      busy_q    <= (ph_d != PH_IDLE);
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_level_o = scl_q;
  assign sda_level_o = sda_q;
  assign busy_res_o  = busy_q;
  assign done_res_o  = done_q;
  assign rx_byte_o   = rx_q;
  assign ack_error_o = aerr_q;
  assign refused_o   = refused_q;

endmodule

[hdl/i2c_master_bit_engine_unit.sv]
// Top level of the I2C master bit engine: configuration registers, front,
// queue and back. Depends on i2c_meb_pkg, i2c_meb_front, i2c_meb_queue, i2c_meb_back.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one line tick per
//   transaction: operation_i, tx_byte_i and the sampled SDA level sda_in_i.
//   Output channel (out_valid_o/out_ready_i) returns one result per tick:
//   driven SCL/SDA, busy, done, last received byte, ack error, refused.
//   Configuration channel (cfg_valid_i/cfg_ready_o) writes register
//   cfg_index_i with cfg_data_i; 0 bus speed, 1 ticks per unit, 2 ack poll
//   limit. It is always ready; write it only while the engine is idle.
//   Results: an accepted tick is written into the command queue, then
//   retired from it into the result register, from which it is presented.
//   Throughput: one tick per cycle while results are taken, set by the
//   back-end sequencer, which retires one queued tick into the result register.
//   Reset: lines released high, sequencer idle, configuration at defaults.
//   Stall: a held result stays stable; the command queue keeps accepting
//   until its QueueDepth entries are full, then in_ready_o drops.
module i2c_master_bit_engine_unit #(
  parameter int unsigned QueueDepth = i2c_meb_pkg::QUEUE_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [i2c_meb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [i2c_meb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [2:0]                         operation_i,
  input  logic [7:0]                         tx_byte_i,
  input  logic                               sda_in_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               scl_level_o,
  output logic                               sda_level_o,
  output logic                               busy_res_o,
  output logic                               done_res_o,
  output logic [7:0]                         rx_byte_o,
  output logic                               ack_error_o,
  output logic                               refused_o
);

  i2c_meb_pkg::cfg_t  cfg_q;
  i2c_meb_pkg::item_t push_item, head_item;
  logic               push, pop, q_full, q_valid;

  // configuration registers; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bus_speed_khz  <= i2c_meb_pkg::BUS_SPEED_RST;
      cfg_q.ticks_per_us   <= i2c_meb_pkg::TICKS_US_RST;
      cfg_q.ack_poll_limit <= i2c_meb_pkg::ACK_LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        i2c_meb_pkg::REG_BUS_SPEED: cfg_q.bus_speed_khz  <= cfg_data_i;
        i2c_meb_pkg::REG_TICKS_US:  cfg_q.ticks_per_us   <= cfg_data_i[7:0];
        i2c_meb_pkg::REG_ACK_LIMIT: cfg_q.ack_poll_limit <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  i2c_meb_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .tx_byte_i   (tx_byte_i),
    .sda_in_i    (sda_in_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .item_o      (push_item)
  );

  i2c_meb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  i2c_meb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (head_item),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .scl_level_o (scl_level_o),
    .sda_level_o (sda_level_o),
    .busy_res_o  (busy_res_o),
    .done_res_o  (done_res_o),
    .rx_byte_o   (rx_byte_o),
    .ack_error_o (ack_error_o),
    .refused_o   (refused_o)
  );

endmodule

[hdl/i2c_meb_checker.sv]
// Port-level checker of the I2C master bit engine, bound to the top level.
// Depends on i2c_master_bit_engine_unit_defines.svh.
`include "i2c_master_bit_engine_unit_defines.svh"

module i2c_meb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       scl_level_o,
  input logic       sda_level_o,
  input logic       busy_res_o,
  input logic       done_res_o,
  input logic [7:0] rx_byte_o
);

  // a finishing tick always leaves the sequencer idle
  `I2C_MEB_ASSERT_IMP(a_done_not_busy, clk_i, rst_ni, out_valid_o && done_res_o, !busy_res_o)

  // with the result register empty the queue cannot be full
  `I2C_MEB_ASSERT_IMP(a_empty_out_ready, clk_i, rst_ni, !out_valid_o, in_ready_o)

  // a stalled result holds its lines and received byte
  `I2C_MEB_ASSERT_NXT(a_stall_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(rx_byte_o) && $stable(scl_level_o) && $stable(sda_level_o))

endmodule

bind i2c_master_bit_engine_unit i2c_meb_checker u_checker (.*);

[tb/i2c_master_bit_engine_unit_test.sv]
// Self-checking testbench for the I2C master bit engine: directed and random line ticks,
// a tick-accurate line predictor and a result scoreboard.
// Depends on i2c_meb_pkg and i2c_master_bit_engine_unit.
module i2c_master_bit_engine_unit_test;
  import i2c_meb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SHOWN_ERRORS = 10;
  // spare operation codes, ignored like no operation
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef enum logic [4:0] {
    ENG_IDLE, ENG_START_A, ENG_START_B, ENG_STOP_A, ENG_STOP_B,
    ENG_WR_SETUP, ENG_WR_HIGH, ENG_WR_LOW, ENG_ACK_REL, ENG_ACK_HIGH, ENG_ACK_POLL,
    ENG_RD_LOW, ENG_RD_HIGH, ENG_AK_LOW, ENG_AK_HIGH
  } eng_phase_e;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] tx;
    logic       sda;
  } line_tick_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       ack_err;
    logic       refused;
  } line_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic [2:0] in_op = OP_NONE;
  logic [7:0] in_tx = 8'h00;
  logic in_sda = 1'b0;
  logic out_ready = 1'b0;
  logic cfg_ready_o, in_ready_o, out_valid_o;
  logic scl_level_o, sda_level_o, busy_res_o, done_res_o, ack_error_o, refused_o;
  logic [7:0] rx_byte_o;

  // testbench control
  logic in_taken = 1'b0;
  logic steady = 1'b0;
  logic hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned ticks_pushed = 0;
  int unsigned ticks_taken = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  line_tick_t tick_backlog[$];
  line_res_t pending_lines[$];

  // predictor configuration and state
  logic [8:0] cfg_speed = BUS_SPEED_RST;
  logic [7:0] cfg_ticks = TICKS_US_RST;
  logic [7:0] cfg_limit = ACK_LIMIT_RST;
  eng_phase_e eng_phase = ENG_IDLE;
  logic [3:0] eng_bit = '0;
  logic [10:0] eng_wait = '0;
  logic [7:0] eng_poll = '0;
  logic [7:0] eng_shift = '0;
  logic eng_ack_after = 1'b0;
  logic eng_scl = 1'b1;
  logic eng_sda = 1'b1;
  logic [7:0] eng_rx = '0;
  logic eng_ackerr = 1'b0;

  i2c_master_bit_engine_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .operation_i (in_op),
    .tx_byte_i   (in_tx),
    .sda_in_i    (in_sda),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .scl_level_o (scl_level_o),
    .sda_level_o (sda_level_o),
    .busy_res_o  (busy_res_o),
    .done_res_o  (done_res_o),
    .rx_byte_o   (rx_byte_o),
    .ack_error_o (ack_error_o),
    .refused_o   (refused_o)
  );

  always #6 clk = ~clk;

  function automatic int unsigned unit_len();
    return (cfg_ticks == 8'd0) ? 1 : int'(cfg_ticks);
  endfunction

  // move to the next phase and load its delay in ticks
  function automatic void arm_wait(input eng_phase_e nxt, input int unsigned units);
    eng_phase = nxt;
    eng_wait = 11'(units * unit_len());
  endfunction

  // one acknowledge poll: low SDA acknowledges, otherwise count until the limit
  function automatic void poll_ack(input logic sda, output logic done);
    done = 1'b0;
    if (!sda) begin
      eng_scl = 1'b0; eng_ackerr = 1'b0; eng_phase = ENG_IDLE; done = 1'b1;
    end else if (eng_poll >= cfg_limit) begin
      eng_scl = 1'b0; eng_ackerr = 1'b1; eng_phase = ENG_IDLE; done = 1'b1;
    end else begin
      eng_poll = eng_poll + 8'd1;
      eng_phase = ENG_ACK_POLL;
    end
  endfunction

  // line state after one accepted tick
  function automatic line_res_t line_tick(input logic [2:0] op, input logic [7:0] tx,
                                          input logic sda);
    line_res_t r;
    logic done, refused, is_cmd;
    done = 1'b0;
    refused = 1'b0;
    is_cmd = (op >= OP_START) && (op <= OP_READ_NACK);
    if (eng_phase == ENG_IDLE) begin
      if (is_cmd && cfg_speed == 9'd0) begin
        refused = 1'b1;
      end else if (is_cmd) begin
        // first line action happens on the accept tick
        case (op)
          OP_START: begin
            eng_sda = 1'b1; eng_scl = 1'b1; arm_wait(ENG_START_A, 4);
          end
          OP_STOP: begin
            eng_scl = 1'b0; eng_sda = 1'b0; arm_wait(ENG_STOP_A, 4);
          end
          OP_WRITE: begin
            eng_scl = 1'b0;
            eng_sda = tx[7];
            eng_shift = {tx[6:0], 1'b0};
            eng_bit = 4'd1;
            arm_wait(ENG_WR_SETUP, 2);
          end
          default: begin
            eng_scl = 1'b0;
            eng_sda = 1'b1;
            eng_shift = 8'h00;
            eng_bit = 4'd0;
            eng_ack_after = (op == OP_READ_ACK);
            arm_wait(ENG_RD_LOW, 2);
          end
        endcase
      end
    end else begin
      refused = is_cmd;
      if (eng_phase == ENG_ACK_POLL) begin
        poll_ack(sda, done);
      end else begin
        if (eng_wait != 11'd0) eng_wait = eng_wait - 11'd1;
        if (eng_wait == 11'd0) begin
          case (eng_phase)
            ENG_START_A: begin eng_sda = 1'b0; arm_wait(ENG_START_B, 4); end
            ENG_START_B: begin eng_scl = 1'b0; eng_phase = ENG_IDLE; done = 1'b1; end
            ENG_STOP_A: begin
              eng_scl = 1'b1; eng_sda = 1'b1; arm_wait(ENG_STOP_B, 4);
            end
            ENG_STOP_B: begin eng_phase = ENG_IDLE; done = 1'b1; end
            ENG_WR_SETUP: begin eng_scl = 1'b1; arm_wait(ENG_WR_HIGH, 2); end
            ENG_WR_HIGH: begin eng_scl = 1'b0; arm_wait(ENG_WR_LOW, 2); end
            ENG_WR_LOW: begin
              if (eng_bit < 4'd8) begin
                eng_sda = eng_shift[7];
                eng_shift = {eng_shift[6:0], 1'b0};
                eng_bit = eng_bit + 4'd1;
                arm_wait(ENG_WR_SETUP, 2);
              end else begin
                eng_sda = 1'b1;
                arm_wait(ENG_ACK_REL, 2);
              end
            end
            ENG_ACK_REL: begin eng_scl = 1'b1; arm_wait(ENG_ACK_HIGH, 2); end
            ENG_ACK_HIGH: begin eng_poll = 8'd0; poll_ack(sda, done); end
            ENG_RD_LOW: begin
              eng_scl = 1'b1;
              eng_shift = {eng_shift[6:0], sda};
              eng_bit = eng_bit + 4'd1;
              arm_wait(ENG_RD_HIGH, 2);
            end
            ENG_RD_HIGH: begin
              eng_scl = 1'b0;
              if (eng_bit < 4'd8) begin
                arm_wait(ENG_RD_LOW, 2);
              end else begin
                eng_sda = !eng_ack_after;
                arm_wait(ENG_AK_LOW, 2);
              end
            end
            ENG_AK_LOW: begin eng_scl = 1'b1; arm_wait(ENG_AK_HIGH, 2); end
            ENG_AK_HIGH: begin
              eng_scl = 1'b0; eng_rx = eng_shift; eng_phase = ENG_IDLE; done = 1'b1;
            end
            default: eng_phase = ENG_IDLE;
          endcase
        end
      end
    end
    // a refused read reports an all-ones byte
    if (refused && op >= OP_READ_ACK) eng_rx = 8'hFF;
    r.scl = eng_scl;
    r.sda = eng_sda;
    r.busy = (eng_phase != ENG_IDLE);
    r.done = done;
    r.rx = eng_rx;
    r.ack_err = eng_ackerr;
    r.refused = refused;
    return r;
  endfunction

  // ticks a command keeps the engine busy after its accept tick
  function automatic int unsigned cmd_span(input logic [2:0] op);
    if (cfg_speed == 9'd0) return 0;
    case (op)
      OP_START, OP_STOP: return 8 * unit_len();
      OP_WRITE: return 52 * unit_len();
      OP_READ_ACK, OP_READ_NACK: return 36 * unit_len();
      default: return 0;
    endcase
  endfunction

  task automatic push_tick(input logic [2:0] op, input logic [7:0] tx, input logic sda);
    line_tick_t t;
    t.op = op;
    t.tx = tx;
    t.sda = sda;
    tick_backlog.push_back(t);
    ticks_pushed++;
  endtask

  task automatic push_none(input int unsigned n, input int unsigned ones_pct);
    repeat (n) push_tick(OP_NONE, 8'($urandom), $urandom_range(0, 99) < ones_pct);
  endtask

  // a command followed by enough quiet ticks to finish it, give or take slack
  task automatic issue(input logic [2:0] op, input logic [7:0] tx,
                       input int unsigned ones_pct, input int slack);
    int span;
    push_tick(op, tx, 1'($urandom_range(0, 1)));
    span = int'(cmd_span(op)) + slack;
    if (span > 0) push_none(span, ones_pct);
  endtask

  // register write transaction, applied to the predictor when accepted
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready_o);
    case (idx)
      REG_BUS_SPEED: cfg_speed = data;
      REG_TICKS_US: cfg_ticks = data[7:0];
      REG_ACK_LIMIT: cfg_limit = data[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_bus(input int unsigned speed, input int unsigned ticks,
                         input int unsigned limit);
    write_reg(REG_BUS_SPEED, 9'(speed));
    write_reg(REG_TICKS_US, 9'(ticks));
    write_reg(REG_ACK_LIMIT, 9'(limit));
  endtask

  // wait for every result, padding with quiet ticks until the engine is idle
  task automatic settle();
    forever begin
      while (ticks_taken != ticks_pushed || pending_lines.size() != 0) @(negedge clk);
      if (eng_phase == ENG_IDLE) break;
      push_none(64, 50);
    end
  endtask

  // random command stream: mostly well-timed, some overlapping or stray
  task automatic random_burst(input int unsigned n_items);
    int unsigned stop_at, pick, ones;
    int slack;
    logic [2:0] op;
    stop_at = ticks_pushed + n_items;
    while (ticks_pushed < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) op = OP_START;
      else if (pick < 30) op = OP_STOP;
      else if (pick < 62) op = OP_WRITE;
      else if (pick < 78) op = OP_READ_ACK;
      else if (pick < 94) op = OP_READ_NACK;
      else if (pick < 97) op = OP_NONE;
      else op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
      ones = ($urandom_range(0, 5) == 0) ? 95 : 50;
      if ($urandom_range(0, 4) == 0) slack = -int'($urandom_range(1, 6));
      else slack = int'($urandom_range(0, 3));
      // a mostly-high SDA may run the acknowledge poll to its limit
      if (op == OP_WRITE && ones > 50) slack += int'(cfg_limit) + 1;
      issue(op, 8'($urandom), ones, slack);
    end
  endtask

  // input driver: new tick offered only once the previous one is taken
  always @(negedge clk) begin : tick_driver
    line_tick_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (tick_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 31)) begin
        nxt = tick_backlog.pop_front();
        in_valid <= 1'b1;
        in_op <= nxt.op;
        in_tx <= nxt.tx;
        in_sda <= nxt.sda;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side ready, with one long hold-off on request
  always @(negedge clk) begin : result_sink
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= 31);
    end
  end

  // monitor: predict on each input transaction, check each result transaction
  always @(posedge clk) begin : line_monitor
    line_res_t got, want;
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready_o) begin
        in_taken = 1'b1;
        ticks_taken++;
        pending_lines.push_back(line_tick(in_op, in_tx, in_sda));
      end
      if (out_valid_o && out_ready) begin
        got = '{scl_level_o, sda_level_o, busy_res_o, done_res_o, rx_byte_o,
                ack_error_o, refused_o};
        if (pending_lines.size() == 0) begin
          errors++;
          if (errors <= SHOWN_ERRORS)
            $display("unexpected result, none predicted: scl/sda/busy/done/rx/ackerr/ref "
                     , "%b/%b/%b/%b/%02h/%b/%b", got.scl, got.sda, got.busy, got.done,
                     got.rx, got.ack_err, got.refused);
        end else begin
          want = pending_lines.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= SHOWN_ERRORS)
              $display("result mismatch: scl/sda/busy/done/rx/ackerr/ref expected "
                       , "%b/%b/%b/%b/%02h/%b/%b got %b/%b/%b/%b/%02h/%b/%b",
                       want.scl, want.sda, want.busy, want.done, want.rx, want.ack_err,
                       want.refused, got.scl, got.sda, got.busy, got.done, got.rx,
                       got.ack_err, got.refused);
          end
        end
      end
    end
  end

  // run limit
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // bus not set up: every command refused, spare codes ignored
    push_tick(OP_NONE, 8'h00, 1'b0);
    push_tick(OP_START, 8'h00, 1'b1);
    push_tick(OP_STOP, 8'hFF, 1'b0);
    push_tick(OP_WRITE, 8'hFF, 1'b1);
    push_tick(OP_READ_ACK, 8'h00, 1'b0);
    push_tick(OP_READ_NACK, 8'h55, 1'b1);
    push_tick(OP_SPARE_6, 8'hAA, 1'b0);
    push_tick(OP_SPARE_7, 8'hFF, 1'b1);
    settle();

    // zero ticks per unit counts as one, no acknowledge polls tolerated
    set_bus(400, 0, 0);
    issue(OP_START, 8'h00, 50, 0);
    issue(OP_WRITE, 8'hFF, 0, 0);
    issue(OP_WRITE, 8'h00, 100, 1);
    issue(OP_READ_ACK, 8'h00, 100, 0);
    issue(OP_READ_NACK, 8'hFF, 0, 0);
    // commands while busy, a refused read among them
    issue(OP_START, 8'h00, 50, -6);
    issue(OP_READ_ACK, 8'h00, 50, -30);
    issue(OP_STOP, 8'h00, 50, 0);
    push_tick(OP_SPARE_6, 8'h00, 1'b1);
    push_tick(OP_SPARE_7, 8'hFF, 1'b0);
    settle();

    // speed above nominal, longest acknowledge timeout
    set_bus(511, 1, 255);
    issue(OP_WRITE, 8'h5A, 100, 257);
    issue(OP_READ_NACK, 8'h00, 50, 0);
    settle();

    // slow waveform with long delays
    set_bus(1, 32, 250);
    issue(OP_START, 8'h00, 50, 0);
    issue(OP_STOP, 8'h00, 50, 0);
    settle();

    set_bus($urandom_range(1, 400), 1, $urandom_range(0, 7));
    random_burst(150);
    settle();

    // receiver holds off while ticks keep coming
    set_bus(511, 2, 0);
    hold_req = 1'b1;
    random_burst(200);
    settle();

    // no idling on either side
    set_bus(300, 0, 255);
    steady = 1'b1;
    random_burst(200);
    settle();
    steady = 1'b0;

    set_bus(0, 3, 4);
    random_burst(60);
    settle();

    set_bus(100, 1, $urandom_range(0, 255));
    random_burst(160);
    settle();

    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
